// File: sv/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the key-value store.
// ----------------------------------------------------------------------------
package lkv_pkg;
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_BYTES_DEF = 8;
    localparam int VAL_BYTES_DEF = 8;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_STAT   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NO_SPACE  = 2'd3;

    localparam logic CFG_ITEM_LIMIT = 1'b0;
    localparam logic CFG_LRU_ENABLE = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NONE,
        DP_START,    // latch input word, clear scan results
        DP_SCAN,     // examine one entry: match, free slot, oldest tracked
        DP_AGE,      // adjust rank of one entry
        DP_WRITE,    // write target entry
        DP_FINISH    // build result word
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       idx_clr;     // restart entry counter
        logic [1:0] age_mode;    // 0 none, 1 untrack target, 2 touch target
        logic       use_victim;
        logic [1:0] wr_mode;     // 0 none, 1 update, 2 insert, 3 delete
        logic       do_touch;
        logic [1:0] status;
        logic       get_ok;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       len_bad;
        logic       last;        // pass done: last entry's read consumed
        logic       found;
        logic       has_free;
        logic       has_victim;
        logic       limit_hit;
        logic       lru_on;
        logic       tgt_tracked;
    } dp_stat_t;

    localparam logic [1:0] AGE_NONE    = 2'd0;
    localparam logic [1:0] AGE_UNTRACK = 2'd1;
    localparam logic [1:0] AGE_TOUCH   = 2'd2;

    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_UPDATE = 2'd1;
    localparam logic [1:0] WR_INSERT = 2'd2;
    localparam logic [1:0] WR_DELETE = 2'd3;
endpackage

// File: sv/lkv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_datapath
// Entry tables, scan registers, rank updates and result register.
// ----------------------------------------------------------------------------
module lkv_datapath
    import lkv_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF,
    parameter int VAL_BYTES = VAL_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [6:0]  cfg_data,
    input  logic [1:0]  in_opcode,
    input  logic [63:0] in_key,
    input  logic [3:0]  in_key_len,
    input  logic [63:0] in_value,
    input  logic [3:0]  in_value_len,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [1:0]  res_status,
    output logic [63:0] res_value,
    output logic [3:0]  res_value_len,
    output logic [6:0]  res_count
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // key and value memory (undefined until written)
    logic [63:0] key_mem [CAPACITY];
    logic [3:0]  klen_mem [CAPACITY];
    logic [63:0] val_mem [CAPACITY];
    logic [3:0]  vlen_mem [CAPACITY];
    logic [IW-1:0] rank_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg, tracked_reg;

    logic [6:0]    limit_reg;
    logic          lru_reg;
    logic [CW-1:0] count_reg;

    logic [1:0]  op_reg;
    logic [63:0] key_reg, val_reg;
    logic [3:0]  klen_reg, vlen_reg;

    logic [IW:0]   idx_reg;     // scan counter, runs one past the last entry to cover the registered read
    logic [IW-1:0] rd_idx_reg;  // address of registered read
    logic          rd_vld_reg;
    logic [63:0]   rd_key_reg;
    logic [3:0]    rd_klen_reg;
    logic [63:0]   rd_val_reg;
    logic [3:0]    rd_vlen_reg;
    logic [IW-1:0] rd_rank_reg;

    logic          found_reg, free_reg, victim_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg, victim_idx_reg, victim_rank_reg;
    logic [IW-1:0] tgt_idx, tgt_rank_reg;
    logic          tgt_tr_reg;
    logic [IW-1:0] gone_rank;

    logic [1:0]  status_reg;
    logic [63:0] fval_reg;
    logic [3:0]  flen_reg;

    function automatic logic [63:0] bmask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) m[b*8 +: 8] = 8'hff;
        end
        return m;
    endfunction

    logic [IW-1:0] cur;
    assign cur = idx_reg[IW-1:0];
    assign tgt_idx = cmd.use_victim ? victim_idx_reg : (found_reg ? hit_idx_reg : free_idx_reg);
    // rank of the entry leaving the recency order: evicted victim or deleted hit
    assign gone_rank = cmd.use_victim ? victim_rank_reg : tgt_rank_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 7'd64;
            lru_reg   <= 1'b1;
        end else if (cfg_we) begin
            if (cfg_idx == CFG_ITEM_LIMIT) limit_reg <= cfg_data;
            else lru_reg <= cfg_data[0];
        end
    end

    // memory read port, one entry per cycle
    always_ff @(posedge aclk) begin
        rd_idx_reg  <= cur;
        rd_key_reg  <= key_mem[cur];
        rd_klen_reg <= klen_mem[cur];
        rd_val_reg  <= val_mem[cur];
        rd_vlen_reg <= vlen_mem[cur];
        rd_rank_reg <= rank_mem[cur];
        if (cmd.op == DP_WRITE) begin
            if (cmd.wr_mode == WR_UPDATE || cmd.wr_mode == WR_INSERT) begin
                val_mem[tgt_idx]  <= val_reg;
                vlen_mem[tgt_idx] <= vlen_reg;
            end
            if (cmd.wr_mode == WR_INSERT) begin
                key_mem[tgt_idx]  <= key_reg;
                klen_mem[tgt_idx] <= klen_reg;
            end
            if (cmd.do_touch) rank_mem[tgt_idx] <= '0;
        end else if (cmd.op == DP_AGE && rd_vld_reg && tracked_reg[rd_idx_reg]
                     && rd_idx_reg != tgt_idx) begin
            if (cmd.age_mode == AGE_UNTRACK && rd_rank_reg > gone_rank)
                rank_mem[rd_idx_reg] <= rd_rank_reg - 1'b1;
            else if (cmd.age_mode == AGE_TOUCH
                     && (!tgt_tr_reg || rd_rank_reg < tgt_rank_reg))
                rank_mem[rd_idx_reg] <= rd_rank_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            tracked_reg <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg    <= '0;
                rd_vld_reg <= 1'b0;
            end else if (cmd.op == DP_SCAN || cmd.op == DP_AGE) begin
                if (idx_reg < (IW+1)'(CAPACITY)) idx_reg <= idx_reg + 1'b1;
                rd_vld_reg <= idx_reg < (IW+1)'(CAPACITY);
            end
            if (cmd.op == DP_AGE && cmd.age_mode == AGE_UNTRACK && !rd_vld_reg)
                tracked_reg[tgt_idx] <= 1'b0;
            if (cmd.op == DP_WRITE) begin
                case (cmd.wr_mode)
                    WR_INSERT: begin
                        valid_reg[tgt_idx]   <= 1'b1;
                        tracked_reg[tgt_idx] <= cmd.do_touch;
                        if (!cmd.use_victim) count_reg <= count_reg + 1'b1;
                    end
                    WR_NONE: if (cmd.do_touch) tracked_reg[tgt_idx] <= 1'b1;
                    WR_UPDATE: if (cmd.do_touch) tracked_reg[tgt_idx] <= 1'b1;
                    WR_DELETE: begin
                        valid_reg[tgt_idx]   <= 1'b0;
                        tracked_reg[tgt_idx] <= 1'b0;
                        if (count_reg != '0) count_reg <= count_reg - 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // scan and result registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_START: begin
                op_reg     <= in_opcode;
                key_reg    <= in_key & bmask(in_key_len);
                klen_reg   <= in_key_len;
                val_reg    <= in_value & bmask(in_value_len);
                vlen_reg   <= in_value_len;
                found_reg  <= 1'b0;
                free_reg   <= 1'b0;
                victim_reg <= 1'b0;
            end
            DP_SCAN: if (rd_vld_reg) begin
                if (valid_reg[rd_idx_reg] && !found_reg && rd_klen_reg == klen_reg
                    && rd_key_reg == key_reg) begin
                    found_reg    <= 1'b1;
                    hit_idx_reg  <= rd_idx_reg;
                    tgt_tr_reg   <= tracked_reg[rd_idx_reg];
                    tgt_rank_reg <= rd_rank_reg;
                    fval_reg     <= rd_val_reg;
                    flen_reg     <= rd_vlen_reg;
                end
                if (!valid_reg[rd_idx_reg] && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
                if (tracked_reg[rd_idx_reg]
                    && (!victim_reg || rd_rank_reg > victim_rank_reg)) begin
                    victim_reg      <= 1'b1;
                    victim_idx_reg  <= rd_idx_reg;
                    victim_rank_reg <= rd_rank_reg;
                end
            end
            DP_AGE: if (!rd_vld_reg && cmd.age_mode == AGE_UNTRACK) begin
                // target slot (victim or deleted hit) is no longer tracked
                tgt_tr_reg <= 1'b0;
            end
            DP_FINISH: begin
                status_reg <= cmd.status;
                if (!cmd.get_ok) begin
                    fval_reg <= '0;
                    flen_reg <= '0;
                end
            end
            default: ;
        endcase
        if (cmd.op == DP_START) tgt_tr_reg <= 1'b0;
    end

    logic lb;
    assign lb = (klen_reg > 4'(KEY_BYTES))
              || (op_reg == OP_PUT && vlen_reg > 4'(VAL_BYTES));

    assign stat.opcode      = op_reg;
    assign stat.len_bad     = lb;
    // pass done once the last entry's read has been consumed
    assign stat.last        = idx_reg == (IW+1)'(CAPACITY) && !rd_vld_reg;
    assign stat.found       = found_reg;
    assign stat.has_free    = free_reg;
    assign stat.has_victim  = victim_reg;
    assign stat.limit_hit   = 32'(count_reg) >= 32'(limit_reg);
    assign stat.lru_on      = lru_reg;
    assign stat.tgt_tracked = tgt_tr_reg;

    assign res_status    = status_reg;
    assign res_value     = fval_reg;
    assign res_value_len = flen_reg;
    assign res_count     = 7'(count_reg);
endmodule

// File: sv/lkv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer: scan, optional rank passes, write, result handshake.
// ----------------------------------------------------------------------------
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_UNTRACK, S_TOUCH, S_WRITE, S_FINISH, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       vic_reg, vic_next;
    logic [1:0] st_reg, st_next;

    logic new_victim;
    assign new_victim = stat.lru_on && stat.limit_hit && stat.has_victim;

    always_comb begin
        state_next = state_reg;
        vic_next   = vic_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.op     = DP_NONE;
        cmd.use_victim = vic_reg;
        cmd.status = st_reg;
        case (state_reg)
            S_IDLE: if (s_valid) begin
                cmd.op     = DP_START;
                vic_next   = 1'b0;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.idx_clr = 1'b1;
                st_next = ST_OK;
                if (stat.opcode == OP_STAT) state_next = S_FINISH;
                else if (stat.len_bad) begin
                    st_next = ST_INVALID;
                    state_next = S_FINISH;
                end else state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.op = DP_SCAN;
                if (stat.last) begin
                    cmd.op      = DP_NONE;
                    cmd.idx_clr = 1'b1;
                    if (stat.found) begin
                        if (stat.opcode == OP_PUT
                            || (stat.opcode == OP_GET && stat.lru_on))
                            state_next = S_TOUCH;
                        else if (stat.opcode == OP_DELETE && stat.tgt_tracked)
                            state_next = S_UNTRACK;
                        else state_next = S_WRITE;
                    end else if (stat.opcode != OP_PUT) begin
                        st_next = ST_NOT_FOUND;
                        state_next = S_FINISH;
                    end else if (new_victim) begin
                        vic_next = 1'b1;
                        state_next = S_UNTRACK;
                    end else if (stat.has_free) begin
                        state_next = stat.lru_on ? S_TOUCH : S_WRITE;
                    end else begin
                        st_next = ST_NO_SPACE;
                        state_next = S_FINISH;
                    end
                end
            end
            S_UNTRACK: begin
                cmd.op = DP_AGE;
                cmd.age_mode = AGE_UNTRACK;
                if (stat.last) begin
                    cmd.op = DP_NONE;
                    cmd.idx_clr = 1'b1;
                    // eviction goes on to insert; delete goes straight to write
                    state_next = vic_reg ? S_TOUCH : S_WRITE;
                end
            end
            S_TOUCH: begin
                cmd.op = DP_AGE;
                cmd.age_mode = AGE_TOUCH;
                if (stat.last) begin
                    cmd.op = DP_NONE;
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.op = DP_WRITE;
                if (!stat.found) begin
                    cmd.wr_mode  = WR_INSERT;
                    cmd.do_touch = stat.lru_on;
                end else if (stat.opcode == OP_PUT) begin
                    cmd.wr_mode  = WR_UPDATE;
                    cmd.do_touch = 1'b1;
                end else if (stat.opcode == OP_GET) begin
                    cmd.wr_mode  = WR_NONE;
                    cmd.do_touch = stat.lru_on;
                end else cmd.wr_mode = WR_DELETE;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.op = DP_FINISH;
                cmd.get_ok = stat.opcode == OP_GET && st_reg == ST_OK;
                state_next = S_OUT;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            vic_reg   <= 1'b0;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            vic_reg   <= vic_next;
            st_reg    <= st_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT;
endmodule

// File: sv/lru_key_value_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_store
// Key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One input word (put, get, delete, stat) on s_* gives one result word on m_*.
// Words are handled one at a time: s_ready is high only while the block is
// idle. Each put, get or delete with legal lengths scans all CAPACITY entries
// through a single registered read port, one entry a cycle. A put of a new
// key that evicts, or a delete of a tracked entry, adds an untrack pass, and
// any touch adds a rank pass. The result holds on m_* until m_ready; no new
// word is taken meanwhile. Reset (aresetn low, synchronous) empties the store
// and sets item_limit to 64 and lru_enable to 1. Configuration writes go
// through cfg_we, cfg_addr and cfg_data; the user makes them only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module lru_key_value_store
    import lkv_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF,
    parameter int VAL_BYTES = VAL_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_key,
    input  logic [3:0]  s_key_len,
    input  logic [63:0] s_value,
    input  logic [3:0]  s_value_len,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_found_value,
    output logic [3:0]  m_found_value_len,
    output logic [6:0]  m_entry_count
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    lkv_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    lkv_datapath #(
        .CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES), .VAL_BYTES(VAL_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_idx(cfg_addr),
        .cfg_data(cfg_data), .in_opcode(s_opcode), .in_key(s_key),
        .in_key_len(s_key_len), .in_value(s_value), .in_value_len(s_value_len),
        .cmd(cmd), .stat(stat), .res_status(m_status), .res_value(m_found_value),
        .res_value_len(m_found_value_len), .res_count(m_entry_count)
    );
endmodule

// File: test/tb_lru_key_value_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_store
// Self-checking bench for the LRU key-value store.
// ----------------------------------------------------------------------------
// A directed table covers length errors, misses, stat and update; directed
// eviction and full-store runs follow, then random phases under several limit
// and LRU settings. Every result word is checked against a behavioral store model in this bench.
// ----------------------------------------------------------------------------
module tb_lru_key_value_store;
    import lkv_pkg::*;

    localparam int NSLOT = 64;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
        logic [3:0]  klen;
        logic [63:0] val;
        logic [3:0]  vlen;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] fval;
        logic [3:0]  flen;
        logic [6:0]  count;
    } rsp_t;

    // directed row: chk = 1 means exp is typed in and compared too
    typedef struct {
        cmd_t c;
        bit   chk;
        rsp_t exp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = '0;
    logic [6:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [63:0] s_key = '0;
    logic [3:0]  s_key_len = '0;
    logic [63:0] s_value = '0;
    logic [3:0]  s_value_len = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [63:0] m_found_value;
    logic [3:0]  m_found_value_len;
    logic [6:0]  m_entry_count;

    lru_key_value_store DUT (.*);

    always #5 aclk = ~aclk;

    // store model
    bit          m_vld [NSLOT];
    logic [63:0] m_key [NSLOT];
    logic [3:0]  m_klen [NSLOT];
    logic [63:0] m_val [NSLOT];
    logic [3:0]  m_vlen [NSLOT];
    bit          m_trk [NSLOT];
    int          m_rank [NSLOT];
    int          m_cnt;
    int          lim_reg = 64;
    bit          lru_reg = 1'b1;

    rsp_t        pending_rsp[$];
    rsp_t        typed_rsp[$];
    bit          typed_chk[$];
    int          errors = 0;
    bit          quiet_out = 1'b0;
    bit          rx_stall_on = 1'b1;

    function automatic logic [63:0] bmask(input logic [3:0] n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic void lose_rank(input int k);
        if (!m_trk[k]) return;
        for (int i = 0; i < NSLOT; i++)
            if (m_trk[i] && i != k && m_rank[i] > m_rank[k]) m_rank[i]--;
        m_trk[k] = 0;
    endfunction

    function automatic void make_newest(input int k);
        for (int i = 0; i < NSLOT; i++)
            if (i != k && m_trk[i] && (!m_trk[k] || m_rank[i] < m_rank[k])) m_rank[i]++;
        m_trk[k] = 1;
        m_rank[k] = 0;
    endfunction

    function automatic rsp_t store_apply(input cmd_t c);
        rsp_t r;
        logic [63:0] k, v;
        int hit, slot, best;
        r = '{ST_OK, 64'd0, 4'd0, 7'd0};
        if (c.op == OP_STAT) begin
        end else if (c.klen > 8 || (c.op == OP_PUT && c.vlen > 8)) begin
            r.status = ST_INVALID;
        end else begin
            k = c.key & bmask(c.klen);
            hit = -1;
            for (int i = 0; i < NSLOT; i++)
                if (hit < 0 && m_vld[i] && m_klen[i] == c.klen && m_key[i] == k) hit = i;
            if (c.op == OP_PUT) begin
                v = c.val & bmask(c.vlen);
                if (hit >= 0) begin
                    m_val[hit] = v;
                    m_vlen[hit] = c.vlen;
                    make_newest(hit);
                end else begin
                    slot = -1;
                    if (lru_reg && m_cnt >= lim_reg) begin
                        best = -1;
                        for (int i = 0; i < NSLOT; i++)
                            if (m_trk[i] && (best < 0 || m_rank[i] > m_rank[best])) best = i;
                        slot = best;
                        if (slot >= 0) lose_rank(slot);
                    end
                    if (slot < 0) begin
                        for (int i = 0; i < NSLOT; i++)
                            if (slot < 0 && !m_vld[i]) slot = i;
                        if (slot >= 0) m_cnt++;
                    end
                    if (slot < 0) begin
                        r.status = ST_NO_SPACE;
                    end else begin
                        m_vld[slot] = 1;
                        m_key[slot] = k;
                        m_klen[slot] = c.klen;
                        m_val[slot] = v;
                        m_vlen[slot] = c.vlen;
                        m_trk[slot] = 0;
                        if (lru_reg) make_newest(slot);
                    end
                end
            end else if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end else if (c.op == OP_GET) begin
                r.fval = m_val[hit];
                r.flen = m_vlen[hit];
                if (lru_reg) make_newest(hit);
            end else begin
                lose_rank(hit);
                m_vld[hit] = 0;
                if (m_cnt > 0) m_cnt--;
            end
        end
        r.count = m_cnt[6:0];
        return r;
    endfunction

    // an idle burst drops valid for its length
    task automatic sender_gap();
        if (!quiet_out && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    task automatic send_word(input cmd_t c, input bit chk, input rsp_t exp);
        sender_gap();
        pending_rsp.push_back(store_apply(c));
        typed_rsp.push_back(exp);
        typed_chk.push_back(chk);
        s_valid <= 1'b1;
        s_opcode <= c.op;
        s_key <= c.key;
        s_key_len <= c.klen;
        s_value <= c.val;
        s_value_len <= c.vlen;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (3 * NSLOT + 20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int d);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= d[6:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_ITEM_LIMIT) lim_reg = d & 127;
        else lru_reg = d[0];
    endtask

    // result checker
    always @(posedge aclk) begin
        rsp_t e, t;
        bit tc;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, m_status);
                errors++;
            end else begin
                e = pending_rsp.pop_front();
                t = typed_rsp.pop_front();
                tc = typed_chk.pop_front();
                if (tc && t != e) begin
                    $display("%0t: table row disagrees: expected st=%0d cnt=%0d, model st=%0d cnt=%0d",
                             $time, t.status, t.count, e.status, e.count);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, m_status);
                    errors++;
                end
                if (m_found_value !== e.fval) begin
                    $display("%0t: found_value expected %h actual %h",
                             $time, e.fval, m_found_value);
                    errors++;
                end
                if (m_found_value_len !== e.flen) begin
                    $display("%0t: found_value_len expected %0d actual %0d",
                             $time, e.flen, m_found_value_len);
                    errors++;
                end
                if (m_entry_count !== e.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, e.count, m_entry_count);
                    errors++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_stall_on && !quiet_out && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        #80ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic cmd_t mk(input logic [1:0] op, input logic [63:0] k,
                                input logic [3:0] kl, input logic [63:0] v,
                                input logic [3:0] vl);
        cmd_t c;
        c.op = op; c.key = k; c.klen = kl; c.val = v; c.vlen = vl;
        return c;
    endfunction

    function automatic rsp_t rs(input logic [1:0] s, input logic [6:0] n);
        rsp_t r;
        r.status = s; r.fval = '0; r.flen = '0; r.count = n;
        return r;
    endfunction

    // key pool keeps hits frequent
    logic [63:0] pool_key [16];
    logic [3:0]  pool_len [16];

    function automatic cmd_t rand_cmd(input int phase_keys);
        cmd_t c;
        int p, sel;
        sel = $urandom_range(0, 99);
        c.op = (sel < 45) ? OP_PUT : (sel < 75) ? OP_GET : (sel < 92) ? OP_DELETE : OP_STAT;
        c.val = {$urandom, $urandom};
        c.vlen = 4'($urandom_range(0, 8));
        if ($urandom_range(0, 19) == 0) c.vlen = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 8) begin
            p = $urandom_range(0, phase_keys - 1);
            c.key = pool_key[p] | ({$urandom, $urandom} & ~bmask(pool_len[p]));
            c.klen = pool_len[p];
        end else begin
            c.key = {$urandom, $urandom};
            c.klen = 4'($urandom_range(0, 15));
        end
        return c;
    endfunction

    initial begin
        row_t tbl[$];
        int lims[6] = '{64, 3, 1, 0, 8, 20};
        bit lrus[6] = '{1, 1, 0, 1, 0, 1};
        int n_items;
        for (int i = 0; i < NSLOT; i++) begin
            m_vld[i] = 0; m_trk[i] = 0; m_rank[i] = 0;
        end
        m_cnt = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tbl.push_back('{mk(OP_STAT, '1, 4'hF, '1, 4'hF), 1, rs(ST_OK, 0)});
        tbl.push_back('{mk(OP_GET, 64'h0, 4'd0, 0, 0), 1, rs(ST_NOT_FOUND, 0)});
        tbl.push_back('{mk(OP_DELETE, 64'h1, 4'd1, 0, 0), 1, rs(ST_NOT_FOUND, 0)});
        tbl.push_back('{mk(OP_PUT, 64'h1, 4'd9, 0, 0), 1, rs(ST_INVALID, 0)});
        tbl.push_back('{mk(OP_PUT, 64'h1, 4'd1, 0, 4'd9), 1, rs(ST_INVALID, 0)});
        tbl.push_back('{mk(OP_GET, 64'h1, 4'hF, 0, 4'hF), 1, rs(ST_INVALID, 0)});
        tbl.push_back('{mk(OP_DELETE, 64'h1, 4'hF, 0, 0), 1, rs(ST_INVALID, 0)});
        tbl.push_back('{mk(OP_PUT, '1, 4'd8, '1, 4'd8), 1, rs(ST_OK, 1)});
        tbl.push_back('{mk(OP_PUT, 64'h0, 4'd0, 64'h55, 4'd0), 1, rs(ST_OK, 2)});
        // same low byte, different length: distinct keys
        tbl.push_back('{mk(OP_PUT, 64'hFFAB, 4'd1, 64'hDEADBEEF_CAFEF00D, 4'd3), 1, rs(ST_OK, 3)});
        tbl.push_back('{mk(OP_PUT, 64'h00AB, 4'd2, 64'h1234, 4'd8), 1, rs(ST_OK, 4)});
        tbl.push_back('{mk(OP_GET, 64'h77AB, 4'd1, 0, 0), 0, rs(0, 0)});
        tbl.push_back('{mk(OP_GET, '1, 4'd8, 0, 0), 0, rs(0, 0)});
        tbl.push_back('{mk(OP_PUT, 64'hAB, 4'd1, 64'h99, 4'd1), 1, rs(ST_OK, 4)});
        tbl.push_back('{mk(OP_GET, 64'hAB, 4'd1, 0, 0), 0, rs(0, 0)});
        tbl.push_back('{mk(OP_DELETE, 64'h0, 4'd0, 0, 0), 1, rs(ST_OK, 3)});
        tbl.push_back('{mk(OP_GET, 64'h0, 4'd0, 0, 0), 1, rs(ST_NOT_FOUND, 3)});
        tbl.push_back('{mk(OP_STAT, 0, 0, 0, 0), 1, rs(ST_OK, 3)});
        foreach (tbl[i]) send_word(tbl[i].c, tbl[i].chk, tbl[i].exp);
        drain();

        // limit 2 with LRU: eviction of the oldest entry
        write_reg(CFG_ITEM_LIMIT, 2);
        send_word(mk(OP_PUT, 64'h10, 4'd1, 64'h1, 4'd1), 0, rs(0, 0));
        send_word(mk(OP_GET, 64'hAB, 4'd1, 0, 0), 0, rs(0, 0));
        send_word(mk(OP_PUT, 64'h11, 4'd1, 64'h2, 4'd1), 0, rs(0, 0));
        drain();

        // LRU off, fill all slots; the puts past that find no space
        write_reg(CFG_LRU_ENABLE, 0);
        write_reg(CFG_ITEM_LIMIT, 127);
        for (int i = 0; i <= NSLOT; i++)
            send_word(mk(OP_PUT, 64'h5000 + 64'(i), 4'd3, 64'(i), 4'd2), i == NSLOT,
                      rs(ST_NO_SPACE, 7'(NSLOT)));
        drain();
        // LRU on, full, count below the limit: no replacement
        write_reg(CFG_LRU_ENABLE, 1);
        send_word(mk(OP_PUT, 64'h7777, 4'd2, 0, 0), 1, rs(ST_NO_SPACE, 7'(NSLOT)));
        send_word(mk(OP_PUT, 64'h5001, 4'd3, 64'h3, 4'd1), 1, rs(ST_OK, 7'(NSLOT)));
        send_word(mk(OP_PUT, 64'h7777, 4'd2, 0, 0), 1, rs(ST_NO_SPACE, 7'(NSLOT)));
        drain();
        for (int i = 0; i < NSLOT; i++)
            send_word(mk(OP_DELETE, 64'h5000 + 64'(i), 4'd3, 0, 0), 0, rs(0, 0));
        drain();

        n_items = 0;
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 16; i++) begin
                pool_len[i] = 4'($urandom_range(0, 8));
                pool_key[i] = {$urandom, $urandom} & bmask(pool_len[i]);
            end
            write_reg(CFG_ITEM_LIMIT, lims[ph]);
            write_reg(CFG_LRU_ENABLE, lrus[ph]);
            if (ph == 5) quiet_out = 1'b1;
            repeat (200) begin
                send_word(rand_cmd((ph % 2) ? 16 : 6), 0, rs(0, 0));
                n_items++;
                if (n_items == 300) drain();
            end
            drain();
        end
        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
